// ----- rtl/mlp_relu_inference_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef MLP_RELU_INFERENCE_MACROS_SVH
`define MLP_RELU_INFERENCE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define MRI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define MRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mri_pkg.sv -----
package mri_pkg;

  localparam int unsigned NumRegs = 6;

  // network dimensions fixed by the port widths
  localparam int unsigned MaxWidth  = 16;
  localparam int unsigned ValueBits = 16;

  localparam logic [1:0] FuncWeight = 2'd0;
  localparam logic [1:0] FuncBias   = 2'd1;
  localparam logic [1:0] FuncInput  = 2'd2;

  localparam logic [2:0] RegLayerCount = 3'd0;
  localparam logic [2:0] RegInputWidth = 3'd1;

  // control handed from the sequencer to the cell row
  typedef struct packed {
    logic load;   // capture new activations into the row
    logic shift;  // rotate the row by one cell
  } mri_row_ctrl_t;

endpackage

// ----- rtl/mri_cell.sv -----
module mri_cell
  import mri_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mri_row_ctrl_t                ctrl_i,
  input  logic signed [VALUE_BITS-1:0] load_i,
  input  logic signed [VALUE_BITS-1:0] nbr_i,
  output logic signed [VALUE_BITS-1:0] data_o
);

  logic signed [VALUE_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_i;
    end else if (ctrl_i.shift) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ----- rtl/mri_row.sv -----
module mri_row
  import mri_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  mri_row_ctrl_t                              ctrl_i,
  input  logic signed [MAX_WIDTH-1:0][VALUE_BITS-1:0] load_i,
  output logic signed [VALUE_BITS-1:0]               head_o
);

  logic signed [MAX_WIDTH-1:0][VALUE_BITS-1:0] data;

  // ring of cells, cell 0 is the head read by the mac
  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
    mri_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl_i),
      .load_i(load_i[g]),
      .nbr_i (data[(g + 1) % MAX_WIDTH]),
      .data_o(data[g])
    );
  end

  assign head_o = data[0];

endmodule

// ----- rtl/mlp_relu_inference.sv -----
// mlp_relu_inference: fixed-point inference of a fully connected relu network
// usage:
// - config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high; write only while the block is idle
// - command channel: start with func/layer/row/col/value/is_last, taken
//   when start is high and busy is low; weight, bias and non-final input
//   transfers leave the block idle, so the next can follow at once
// - an input transfer marked last runs all configured layers; each output
//   row goes through a fetch and load of the cell row, one multiply-accumulate
//   per input on the single mac, a drain and a write back, and the first
//   result shows only after the last layer has been written back
// - results follow on out_valid_o, one element per cycle, for one cycle
//   each; the receiver cannot stall, so the block never waits on it
// - busy is high from the last input until the final result is shown, and
//   a new transfer can be taken in the cycle that shows it
// - reset clears registers to defaults and activations to zero; weight and
//   bias memories are not cleared and must be written before use
module mlp_relu_inference
  import mri_pkg::*;
#(
  parameter int unsigned MAX_LAYERS    = 4,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [1:0]  layer_pick_i,
  input  logic [3:0]  row_pick_i,
  input  logic [3:0]  col_pick_i,
  input  logic signed [15:0] value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  output logic [3:0]  out_index_o,
  output logic [14:0] out_value_o,
  output logic        out_last_o
);

`include "mlp_relu_inference_macros.svh"

  localparam int unsigned MAX_WIDTH  = MaxWidth;
  localparam int unsigned VALUE_BITS = ValueBits;
  localparam int unsigned LB   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned WB   = $clog2(MAX_WIDTH);
  localparam int unsigned CB   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ACCB = 2 * VALUE_BITS + WB + 2;
  localparam int unsigned LIM  = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam int unsigned WAB  = $clog2(MAX_LAYERS * MAX_WIDTH * MAX_WIDTH);
  localparam int unsigned BAB  = $clog2(MAX_LAYERS * MAX_WIDTH);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;  // row fetch and cell row load
  localparam logic [2:0] StMac  = 3'd2;
  localparam logic [2:0] StDone = 3'd3;  // drain the last product
  localparam logic [2:0] StNext = 3'd4;  // write result, then next row or layer
  localparam logic [2:0] StOut  = 3'd5;

  // configuration registers
  logic [2:0] layer_count_q;
  logic [4:0] width_q [5];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd1;
      for (int i = 0; i < 5; i++) width_q[i] <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegLayerCount) begin
        layer_count_q <= cfg_data_i[2:0];
      end else if (cfg_index_i < 3'(NumRegs)) begin
        width_q[cfg_index_i - RegInputWidth] <= cfg_data_i;
      end
    end
  end

  function automatic logic [CB-1:0] clamp_w(input logic [4:0] w);
    logic [CB-1:0] r;
    if (w == 5'd0) r = CB'(1);
    else if (32'(w) > MAX_WIDTH) r = CB'(MAX_WIDTH);
    else r = CB'(w);
    return r;
  endfunction

  logic [2:0] layers;
  always_comb begin
    layers = layer_count_q;
    if (layers == 3'd0) layers = 3'd1;
    if (32'(layers) > LIM) layers = 3'(LIM);
  end

  // weight and bias memories, registered reads
  logic signed [VALUE_BITS-1:0] wmem [MAX_LAYERS*MAX_WIDTH*MAX_WIDTH];
  logic signed [VALUE_BITS-1:0] bmem [MAX_LAYERS*MAX_WIDTH];
  logic signed [VALUE_BITS-1:0] wrd_q, brd_q;

  // activation staging (front) written by inputs and at layer end
  logic signed [MAX_WIDTH-1:0][VALUE_BITS-1:0] front_q, back_q;

  logic [2:0]    st_q;
  logic [LB-1:0] lay_q;
  logic [WB-1:0] row_q, col_q;
  logic [CB-1:0] in_w_q, out_w_q, cnt_q;
  logic [WB:0]   fetched_q;
  logic signed [ACCB-1:0] acc_q;
  logic          mac_v_q;
  logic signed [VALUE_BITS-1:0] head;
  mri_row_ctrl_t ctrl;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (st_q != StIdle);

  logic [LB-1:0] wl;
  assign wl = LB'(layer_pick_i);

  // memory addresses: layer, row and column fields side by side
  logic [WAB-1:0] waddr_wr, waddr_rd;
  logic [BAB-1:0] baddr_wr, baddr_rd;
  assign waddr_wr = WAB'({wl, row_pick_i, col_pick_i});
  assign waddr_rd = WAB'({lay_q, row_q, col_q});
  assign baddr_wr = BAB'({wl, row_pick_i});
  assign baddr_rd = BAB'({lay_q, row_q});

  always_ff @(posedge clk_i) begin
    if (accept && func_i == FuncWeight && 32'(layer_pick_i) < MAX_LAYERS) begin
      wmem[waddr_wr] <= value_i;
    end
    if (accept && func_i == FuncBias && 32'(layer_pick_i) < MAX_LAYERS) begin
      bmem[baddr_wr] <= value_i;
    end
    wrd_q <= wmem[waddr_rd];
    brd_q <= bmem[baddr_rd];
  end

  assign ctrl.load  = (st_q == StLoad && fetched_q == '0);
  assign ctrl.shift = (st_q == StMac);

  mri_row #(.MAX_WIDTH(MAX_WIDTH), .VALUE_BITS(VALUE_BITS)) u_row (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .load_i(front_q),
    .head_o(head)
  );

  // saturate and relu on the final sum
  logic signed [ACCB-1:0] shifted;
  logic [VALUE_BITS-2:0]  res;
  assign shifted = acc_q >>> FRACTION_BITS;
  always_comb begin
    if (shifted < 0) res = '0;
    else if (shifted > ACCB'((1 << (VALUE_BITS - 1)) - 1)) res = '1;
    else res = shifted[VALUE_BITS-2:0];
  end

  logic signed [2*VALUE_BITS-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; lay_q <= '0; row_q <= '0; col_q <= '0;
      in_w_q <= '0; out_w_q <= '0; cnt_q <= '0; fetched_q <= '0;
      acc_q <= '0; mac_v_q <= 1'b0; prod_q <= '0;
      front_q <= '0; back_q <= '0;
      out_valid_o <= 1'b0; out_index_o <= '0; out_value_o <= '0; out_last_o <= 1'b0;
    end else begin
      out_valid_o <= (st_q == StOut);
      case (st_q)
        StIdle: begin
          if (accept && func_i == FuncInput) begin
            front_q[col_pick_i[WB-1:0]] <= value_i;
            if (is_last_i) begin
              st_q <= StLoad; lay_q <= '0; row_q <= '0; col_q <= '0;
              in_w_q <= clamp_w(width_q[0]);
              out_w_q <= clamp_w(width_q[1]);
              fetched_q <= '0;
            end
          end
        end
        StLoad: begin
          // stay here while the memory read and the row load complete
          fetched_q <= fetched_q + 1'b1;
          if (fetched_q != '0) begin
            st_q <= StMac; cnt_q <= '0; col_q <= col_q + 1'b1;
            acc_q <= '0; mac_v_q <= 1'b0;
          end
        end
        StMac: begin
          // product of current weight and head cell, then accumulate
          prod_q <= wrd_q * head;
          mac_v_q <= 1'b1;
          if (cnt_q == '0) acc_q <= ACCB'(brd_q) <<< FRACTION_BITS;
          if (mac_v_q) acc_q <= ((cnt_q == CB'(1)) ? (ACCB'(brd_q) <<< FRACTION_BITS)
                                 : acc_q) + ACCB'(prod_q);
          cnt_q <= cnt_q + 1'b1;
          col_q <= col_q + 1'b1;
          if (cnt_q + 1'b1 == in_w_q) st_q <= StDone;
        end
        StDone: begin
          acc_q <= acc_q + ACCB'(prod_q);
          st_q <= StNext;
        end
        StNext: begin
          back_q[row_q] <= VALUE_BITS'({1'b0, res});
          if (CB'(row_q) + 1'b1 == out_w_q) begin
            for (int i = 0; i < MAX_WIDTH; i++)
              if (CB'(i) < out_w_q) front_q[i] <= (i == int'(row_q)) ?
                VALUE_BITS'({1'b0, res}) : back_q[i];
            if (3'(lay_q) + 3'd1 == layers) begin
              st_q <= StOut; row_q <= '0;
            end else begin
              lay_q <= lay_q + 1'b1; row_q <= '0; col_q <= '0;
              in_w_q <= out_w_q;
              out_w_q <= clamp_w(width_q[3'(lay_q) + 3'd2]);
              fetched_q <= '0; st_q <= StLoad;
            end
          end else begin
            row_q <= row_q + 1'b1; col_q <= '0; fetched_q <= '0; st_q <= StLoad;
          end
        end
        StOut: begin
          out_index_o <= 4'(row_q);
          out_value_o <= 15'(front_q[row_q]);
          out_last_o  <= (CB'(row_q) + 1'b1 == out_w_q);
          row_q <= row_q + 1'b1;
          if (CB'(row_q) + 1'b1 == out_w_q) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  `MRI_ASSERT_IMPL(a_out_only_busy, clk_i, rst_ni, out_valid_o && !out_last_o, busy)
  `MRI_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, out_valid_o && out_last_o, !out_valid_o)
  `MRI_ASSERT_IMPL(a_no_shift_load, clk_i, rst_ni, ctrl.load, !ctrl.shift)

endmodule

// ----- sim/tb_mlp_relu_inference.sv -----
`timescale 1ns / 1ps

module tb_mlp_relu_inference;
  import mri_pkg::*;

  // codes the package does not name
  localparam logic [1:0] FuncUnused  = 2'd3;
  localparam logic [2:0] RegWidthL0  = 3'd2;
  localparam logic [2:0] RegWidthL1  = 3'd3;
  localparam logic [2:0] RegWidthL2  = 3'd4;
  localparam logic [2:0] RegWidthL3  = 3'd5;
  localparam int         WatchLimit  = 20000;

  typedef struct {
    logic [1:0]         func;
    logic [1:0]         layer;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
    bit                 has_exp;  // typed-in single result instead of predicted
    logic [14:0]        exp_val;
  } cmd_t;

  typedef struct {
    logic [3:0]  idx;
    logic [14:0] val;
    logic        last;
  } elem_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [4:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func_i = '0;
  logic [1:0] layer_pick_i = '0;
  logic [3:0] row_pick_i = '0;
  logic [3:0] col_pick_i = '0;
  logic signed [15:0] value_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic [3:0] out_index_o;
  logic [14:0] out_value_o;
  logic out_last_o;

  mlp_relu_inference dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start, .busy, .func_i, .layer_pick_i, .row_pick_i, .col_pick_i, .value_i,
    .is_last_i, .out_valid_o, .out_index_o, .out_value_o, .out_last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the network state
  logic signed [15:0] weight_mem [4][16][16];
  logic signed [15:0] bias_mem [4][16];
  logic signed [15:0] act_vec [16];
  int                 cfg_shadow [6];
  elem_t              pending_out [$];

  int err_count = 0;
  int items_sent = 0;
  int evals_run = 0;
  int outs_seen = 0;
  int idle_pct = 0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int clamp_w(input int w);
    if (w < 1) return 1;
    if (w > 16) return 16;
    return w;
  endfunction

  // runs every layer as relu(W*x+b) on the shadow state, returns output width
  function automatic int run_network();
    logic signed [15:0] nxt [16];
    longint acc;
    int layers, in_w, out_w;
    layers = cfg_shadow[RegLayerCount];
    if (layers < 1) layers = 1;
    if (layers > 4) layers = 4;
    in_w = clamp_w(cfg_shadow[RegInputWidth]);
    out_w = in_w;
    for (int l = 0; l < layers; l++) begin
      out_w = clamp_w(cfg_shadow[RegWidthL0 + l]);
      for (int r = 0; r < out_w; r++) begin
        acc = longint'(bias_mem[l][r]) * 256;
        for (int c = 0; c < in_w; c++)
          acc += longint'(weight_mem[l][r][c]) * longint'(act_vec[c]);
        acc = acc >>> 8;  // floor
        if (acc > 32767) acc = 32767;
        if (acc < 0) acc = 0;
        nxt[r] = acc[15:0];
      end
      for (int r = 0; r < out_w; r++) act_vec[r] = nxt[r];
      in_w = out_w;
    end
    return out_w;
  endfunction

  // update shadow state for one accepted command and queue its results
  function automatic void predict_cmd(input cmd_t c);
    int n;
    elem_t e;
    case (c.func)
      FuncWeight: weight_mem[c.layer][c.row][c.col] = c.value;
      FuncBias:   bias_mem[c.layer][c.row] = c.value;
      FuncInput: begin
        act_vec[c.col] = c.value;
        if (c.last) begin
          n = run_network();
          evals_run++;
          if (c.has_exp) begin
            e.idx = '0; e.val = c.exp_val; e.last = 1'b1;
            pending_out = {pending_out, e};
          end else begin
            for (int i = 0; i < n; i++) begin
              e.idx = i[3:0];
              e.val = act_vec[i][14:0];
              e.last = (i == n - 1);
              pending_out = {pending_out, e};
            end
          end
        end
      end
      default: ;  // unused code, ignored
    endcase
  endfunction

  // one command transfer, with an optional gap before it
  task automatic issue(input cmd_t c, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= c.func;
    layer_pick_i <= c.layer;
    row_pick_i <= c.row;
    col_pick_i <= c.col;
    value_i <= c.value;
    is_last_i <= c.last;
    do @(posedge clk_i); while (busy);
    predict_cmd(c);
    items_sent++;
  endtask

  // valid stays high across back to back writes, set_regs drops it
  task automatic write_reg(input logic [2:0] idx, input logic [4:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_shadow[idx] = (idx == RegLayerCount) ? int'(data[2:0]) : int'(data);
  endtask

  // all results in and the mac quiet before touching registers
  task automatic drain();
    start <= 1'b0;
    while (pending_out.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [4:0] lc, input logic [4:0] iw,
                          input logic [4:0] w0, input logic [4:0] w1,
                          input logic [4:0] w2, input logic [4:0] w3);
    write_reg(RegLayerCount, lc);
    write_reg(RegInputWidth, iw);
    write_reg(RegWidthL0, w0);
    write_reg(RegWidthL1, w1);
    write_reg(RegWidthL2, w2);
    write_reg(RegWidthL3, w3);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small q8.8 values so deep layers stay away from the rails
  function automatic logic signed [15:0] rand_value();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(1023)) - 512);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(99) < idle_pct) return $urandom_range(5, 1);
    return 0;
  endfunction

  // result monitor: strobe lasts one cycle and cannot be stalled
  always @(posedge clk_i) begin
    elem_t e;
    if (rst_ni && out_valid_o) begin
      outs_seen++;
      if (pending_out.size() == 0) begin
        report($sformatf("unexpected result idx=%0d val=%0h", out_index_o, out_value_o));
      end else begin
        e = pending_out.pop_front();
        if (out_index_o !== e.idx)
          report($sformatf("out_index %0d, want %0d", out_index_o, e.idx));
        if (out_value_o !== e.val)
          report($sformatf("out_value %0h, want %0h (idx %0d)", out_value_o, e.val, e.idx));
        if (out_last_o !== e.last)
          report($sformatf("out_last %0b, want %0b (idx %0d)", out_last_o, e.last, e.idx));
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("FAIL mlp_relu_inference");
      $finish;
    end
  end

  // directed rows run with one layer of width one, so results read off directly
  cmd_t dir_tab [20];

  initial begin
    cmd_t c;
    int n_items;
    logic [4:0] lc, iw;
    logic [4:0] ws [4];

    dir_tab = '{
      // plain pass-through with unit weight
      '{FuncWeight, 2'd0, 4'd0, 4'd0, 16'sh0100, 1'b0, 1'b0, 15'h0},
      '{FuncBias,   2'd0, 4'd0, 4'd0, 16'sh0000, 1'b0, 1'b0, 15'h0},
      '{FuncInput,  2'd0, 4'd0, 4'd0, 16'sh0200, 1'b1, 1'b1, 15'h0200},
      // negative sum clipped by relu
      '{FuncInput,  2'd0, 4'd0, 4'd0, -16'sh8000, 1'b1, 1'b1, 15'h0},
      // positive saturation
      '{FuncWeight, 2'd0, 4'd0, 4'd0, 16'sh7fff, 1'b0, 1'b0, 15'h0},
      '{FuncInput,  2'd0, 4'd0, 4'd0, 16'sh7fff, 1'b1, 1'b1, 15'h7fff},
      // bias alone at both extremes
      '{FuncWeight, 2'd0, 4'd0, 4'd0, 16'sh0000, 1'b0, 1'b0, 15'h0},
      '{FuncBias,   2'd0, 4'd0, 4'd0, 16'sh7fff, 1'b0, 1'b0, 15'h0},
      '{FuncInput,  2'd0, 4'd0, 4'd0, 16'sh0000, 1'b1, 1'b1, 15'h7fff},
      '{FuncBias,   2'd0, 4'd0, 4'd0, -16'sh8000, 1'b0, 1'b0, 15'h0},
      '{FuncInput,  2'd0, 4'd0, 4'd0, 16'sh0000, 1'b1, 1'b1, 15'h0},
      // unused code and last flag on writes are ignored
      '{FuncUnused, 2'd3, 4'd15, 4'd15, 16'shffff, 1'b1, 1'b0, 15'h0},
      '{FuncWeight, 2'd3, 4'd15, 4'd15, 16'shffff, 1'b1, 1'b0, 15'h0},
      '{FuncBias,   2'd3, 4'd15, 4'd0, 16'sh5555, 1'b1, 1'b0, 15'h0},
      // element outside the input width, then smallest step
      '{FuncInput,  2'd0, 4'd0, 4'd15, 16'sh1234, 1'b0, 1'b0, 15'h0},
      '{FuncWeight, 2'd0, 4'd0, 4'd0, 16'sh0100, 1'b0, 1'b0, 15'h0},
      '{FuncBias,   2'd0, 4'd0, 4'd0, 16'sh0000, 1'b0, 1'b0, 15'h0},
      '{FuncInput,  2'd0, 4'd0, 4'd0, 16'sh0001, 1'b1, 1'b1, 15'h0001},
      // small negative bias taken from the sum
      '{FuncBias,   2'd0, 4'd0, 4'd0, -16'sh0001, 1'b0, 1'b0, 15'h0},
      '{FuncInput,  2'd0, 4'd0, 4'd0, 16'sh0003, 1'b1, 1'b1, 15'h0002}
    };

    for (int i = 0; i < 6; i++) cfg_shadow[i] = (i == 0) ? 1 : 16;
    foreach (act_vec[i]) act_vec[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // fill every weight and bias that the register settings below can read:
    // a 6x6 corner of each layer, plus row 0 and column 0 of layer 0 and all its biases
    for (int l = 0; l < 4; l++)
      for (int r = 0; r < 16; r++) begin
        if (r < 6 || l == 0) begin
          c = '{FuncBias, l[1:0], r[3:0], 4'd0, rand_value(), 1'b0, 1'b0, 15'h0};
          issue(c, 0);
        end
        for (int k = 0; k < 16; k++) begin
          if ((r < 6 && k < 6) || (l == 0 && (r == 0 || k == 0))) begin
            c = '{FuncWeight, l[1:0], r[3:0], k[3:0], rand_value(), 1'b0, 1'b0, 15'h0};
            issue(c, 0);
          end
        end
      end

    drain();
    set_regs(5'd1, 5'd1, 5'd1, 5'd16, 5'd16, 5'd16);
    foreach (dir_tab[i]) issue(dir_tab[i], 0);

    // random phases, each with its own register setting; idle pattern set per pair of phases
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin lc = 5'd4; iw = 5'd6;  ws = '{5'd6, 5'd6, 5'd6, 5'd6}; end
        1: begin lc = 5'd0; iw = 5'd31; ws = '{5'd0, 5'd31, 5'd0, 5'd31}; end
        2: begin lc = 5'd7; iw = 5'd5;  ws = '{5'd3, 5'd5, 5'd1, 5'd6}; end
        3: begin lc = 5'd1; iw = 5'd1;  ws = '{5'd31, 5'd4, 5'd2, 5'd2}; end
        default: begin
          lc = 5'($urandom_range(7));
          iw = 5'($urandom_range(6));
          foreach (ws[i]) ws[i] = 5'($urandom_range(6));
        end
      endcase
      set_regs(lc, iw, ws[0], ws[1], ws[2], ws[3]);
      idle_pct = (ph < 2) ? 18 : (ph < 4) ? 53 : 0;
      n_items = 0;
      while (n_items < 22) begin
        int sel;
        sel = $urandom_range(99);
        c.layer = 2'($urandom); c.row = 4'($urandom); c.col = 4'($urandom);
        c.value = rand_value(); c.last = 1'($urandom);
        c.has_exp = 1'b0; c.exp_val = '0;
        if (sel < 18) c.func = FuncWeight;
        else if (sel < 25) c.func = FuncBias;
        else if (sel < 29) c.func = FuncUnused;
        else begin
          c.func = FuncInput;
          c.last = ($urandom_range(5) == 0);
        end
        issue(c, pick_gap());
        if (c.func != FuncUnused) n_items++;
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d commands, %0d network runs, %0d output elements",
             items_sent, evals_run, outs_seen);
    $display("register settings swept through clamped, narrow and four-layer networks");
    if (err_count == 0) begin
      $display("PASS mlp_relu_inference");
    end else begin
      $display("FAIL mlp_relu_inference");
    end
    $finish;
  end

endmodule
